### src/rsms_pkg.sv
// Shared types, widths and elaboration helpers for the run-split merge sorter.
package rsms_pkg;

  localparam int unsigned DataW = 16;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    is_final;
  } rsms_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_set;
    logic                    overflowed;
  } rsms_out_t;

  // Integer square root, used at elaboration to size the run bookkeeping.
  function automatic int isqrt(input int n);
    int r;
    r = 1;
    while ((r + 1) * (r + 1) <= n) begin
      r++;
    end
    return r;
  endfunction

endpackage

### src/rsms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsms_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/run_split_merge_sorter.sv
// Loads a set of signed samples one per transaction into a RAM. The transaction marked
// is_final closes the set (its sample is stored too; samples past CAPACITY are dropped and
// every result of that set carries overflowed). The set of n values is then cut into
// r = isqrt(n) runs of ceil(n/r) entries (the last run may be shorter), each run is
// insertion-sorted in place in the RAM, and the runs are merged by scanning the run heads,
// one RAM read per run. While loading, a sample is taken whenever one is offered. Setup
// counts up r and then the run length. Sorting a run moves each entry down past every
// larger neighbour. Each merged result needs a scan of every run head through the single
// RAM read port. The time spent sorting depends on the input order. No input is taken
// while a set is being sorted or emitted; the next set may start while the last result
// still waits in the output register.
module run_split_merge_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                rst_ni,
  input  logic                clk_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rsms_pkg::rsms_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsms_pkg::rsms_out_t out_o
);
  import rsms_pkg::*;

  localparam int unsigned AddrW    = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 2);
  localparam int unsigned MaxRuns  = isqrt(CAPACITY);
  localparam int unsigned IdxW     = (MaxRuns > 1) ? $clog2(MaxRuns) : 1;
  localparam int unsigned RunSlots = 2 ** IdxW;
  localparam int unsigned RunCntW  = IdxW + 1;
  localparam int unsigned ProdW    = 2 * (RunCntW + 1) + CntW;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_ROOT     = 4'd1;
  localparam logic [3:0] S_LEN      = 4'd2;
  localparam logic [3:0] S_SRT_RUN  = 4'd3;
  localparam logic [3:0] S_SRT_NEXT = 4'd4;
  localparam logic [3:0] S_SRT_V    = 4'd5;
  localparam logic [3:0] S_SRT_CMP  = 4'd6;
  localparam logic [3:0] S_SRT_PUT  = 4'd7;
  localparam logic [3:0] S_MRG_SCAN = 4'd8;
  localparam logic [3:0] S_MRG_EMIT = 4'd9;

  logic [3:0]               state_q;
  logic [CntW-1:0]          fill_q;
  logic                     ovf_q;
  logic [RunCntW-1:0]       runs_q;
  logic [CntW-1:0]          len_q;
  logic [CntW-1:0]          base_q;
  logic [RunCntW-1:0]       k_q;
  logic [CntW-1:0]          lo_q;
  logic [CntW-1:0]          hi_q;
  logic [CntW-1:0]          i_q;
  logic [CntW-1:0]          j_q;
  logic signed [DataW-1:0]  v_q;
  logic [CntW-1:0]          heads_q [RunSlots];
  logic [CntW-1:0]          ends_q  [RunSlots];
  logic [RunCntW-1:0]       sc_q;
  logic                     pv_q;
  logic [CntW-1:0]          cur_head_q;
  logic                     cur_act_q;
  logic [IdxW-1:0]          cur_idx_q;
  logic                     best_found_q;
  logic signed [DataW-1:0]  best_val_q;
  logic [IdxW-1:0]          best_idx_q;
  logic [CntW-1:0]          best_head_q;
  logic [CntW-1:0]          h_q;
  rsms_out_t                out_q;
  logic                     out_valid_q;

  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [DataW-1:0]         ram_wdata;
  logic [AddrW-1:0]         ram_raddr;
  logic [DataW-1:0]         ram_rdata;
  logic signed [DataW-1:0]  rd_val;

  logic [CntW:0]            sum_hi;
  logic [CntW-1:0]          run_hi;
  logic [ProdW-1:0]         root_sq;
  logic [ProdW-1:0]         len_prod;
  logic [CntW-1:0]          i_m1;
  logic [CntW-1:0]          j_m1;
  logic [CntW-1:0]          j_m2;
  logic [IdxW-1:0]          sc_idx;
  logic [IdxW-1:0]          k_idx;
  logic                     sc_live;
  logic                     emit_go;
  logic                     take_best;

  rsms_ram #(
    .Width(DataW),
    .Depth(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_val   = $signed(ram_rdata);
  assign sum_hi   = {1'b0, base_q} + {1'b0, len_q};
  assign run_hi   = (sum_hi > {1'b0, fill_q}) ? fill_q : sum_hi[CntW-1:0];
  assign root_sq  = (ProdW'(runs_q) + ProdW'(1)) * (ProdW'(runs_q) + ProdW'(1));
  assign len_prod = ProdW'(len_q) * ProdW'(runs_q);
  assign i_m1     = i_q - CntW'(1);
  assign j_m1     = j_q - CntW'(1);
  assign j_m2     = j_q - CntW'(2);
  assign sc_idx   = sc_q[IdxW-1:0];
  assign k_idx    = k_q[IdxW-1:0];
  assign sc_live  = (sc_q < runs_q);
  assign emit_go  = (state_q == S_MRG_EMIT) && (!out_valid_q || out_ready_i);
  assign take_best = pv_q && cur_act_q && (!best_found_q || (rd_val < best_val_q));

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_q[AddrW-1:0];
    ram_wdata = v_q;
    ram_raddr = i_q[AddrW-1:0];
    case (state_q)
      S_LOAD: begin
        ram_we    = in_valid_i && (fill_q < CntW'(CAPACITY));
        ram_waddr = fill_q[AddrW-1:0];
        ram_wdata = in_i.sample;
      end
      S_SRT_NEXT: ram_raddr = i_q[AddrW-1:0];
      S_SRT_V:    ram_raddr = i_m1[AddrW-1:0];
      S_SRT_CMP: begin
        ram_we    = 1'b1;
        ram_raddr = j_m2[AddrW-1:0];
        // shift the larger neighbor up, or drop the held value into its slot
        ram_wdata = (rd_val > v_q) ? ram_rdata : v_q;
      end
      S_SRT_PUT:  ram_we = 1'b1;
      S_MRG_SCAN: ram_raddr = heads_q[sc_idx][AddrW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      fill_q       <= '0;
      ovf_q        <= 1'b0;
      runs_q       <= RunCntW'(1);
      len_q        <= CntW'(1);
      base_q       <= '0;
      k_q          <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      i_q          <= '0;
      j_q          <= '0;
      v_q          <= '0;
      for (int s = 0; s < RunSlots; s++) begin
        heads_q[s] <= '0;
        ends_q[s]  <= '0;
      end
      sc_q         <= '0;
      pv_q         <= 1'b0;
      cur_head_q   <= '0;
      cur_act_q    <= 1'b0;
      cur_idx_q    <= '0;
      best_found_q <= 1'b0;
      best_val_q   <= '0;
      best_idx_q   <= '0;
      best_head_q  <= '0;
      h_q          <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (fill_q < CntW'(CAPACITY)) begin
              fill_q <= fill_q + CntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_i.is_final) begin
              runs_q  <= RunCntW'(1);
              state_q <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (root_sq <= ProdW'(fill_q)) begin
            runs_q <= runs_q + RunCntW'(1);
          end else begin
            len_q   <= CntW'(1);
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          if (len_prod < ProdW'(fill_q)) begin
            len_q <= len_q + CntW'(1);
          end else begin
            base_q  <= '0;
            k_q     <= '0;
            state_q <= S_SRT_RUN;
          end
        end
        S_SRT_RUN: begin
          if (k_q == runs_q) begin
            sc_q         <= '0;
            pv_q         <= 1'b0;
            best_found_q <= 1'b0;
            h_q          <= '0;
            state_q      <= S_MRG_SCAN;
          end else begin
            heads_q[k_idx] <= base_q;
            ends_q[k_idx]  <= run_hi;
            lo_q           <= base_q;
            hi_q           <= run_hi;
            i_q            <= base_q + CntW'(1);
            base_q         <= run_hi;
            state_q        <= S_SRT_NEXT;
          end
        end
        S_SRT_NEXT: begin
          if (i_q < hi_q) begin
            state_q <= S_SRT_V;
          end else begin
            k_q     <= k_q + RunCntW'(1);
            state_q <= S_SRT_RUN;
          end
        end
        S_SRT_V: begin
          v_q     <= rd_val;
          j_q     <= i_q;
          state_q <= S_SRT_CMP;
        end
        S_SRT_CMP: begin
          if (rd_val > v_q) begin
            j_q <= j_m1;
            if (j_m1 <= lo_q) begin
              state_q <= S_SRT_PUT;
            end
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_SRT_NEXT;
          end
        end
        S_SRT_PUT: begin
          i_q     <= i_q + CntW'(1);
          state_q <= S_SRT_NEXT;
        end
        S_MRG_SCAN: begin
          // one head read in flight, the previous one compared
          pv_q <= sc_live;
          if (sc_live) begin
            cur_head_q <= heads_q[sc_idx];
            cur_act_q  <= heads_q[sc_idx] < ends_q[sc_idx];
            cur_idx_q  <= sc_idx;
            sc_q       <= sc_q + RunCntW'(1);
          end else begin
            state_q <= S_MRG_EMIT;
          end
          if (take_best) begin
            best_found_q <= 1'b1;
            best_val_q   <= rd_val;
            best_idx_q   <= cur_idx_q;
            best_head_q  <= cur_head_q;
          end
        end
        S_MRG_EMIT: begin
          if (emit_go) begin
            out_q.sorted_value  <= best_val_q;
            out_q.end_of_set    <= (h_q + CntW'(1) == fill_q);
            out_q.overflowed    <= ovf_q;
            heads_q[best_idx_q] <= best_head_q + CntW'(1);
            h_q                 <= h_q + CntW'(1);
            if (h_q + CntW'(1) == fill_q) begin
              fill_q  <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              sc_q         <= '0;
              pv_q         <= 1'b0;
              best_found_q <= 1'b0;
              state_q      <= S_MRG_SCAN;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_runs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    runs_q <= RunCntW'(MaxRuns))
    else $error("run count exceeds slot count");

  a_final_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.is_final |=> state_q == S_ROOT)
    else $error("final transaction did not start the sort");

  a_emit_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MRG_EMIT |-> best_found_q)
    else $error("merge emitted without a live run head");

endmodule
